// ===== rtl/bgrle_pkg.sv =====
package bgrle_pkg;

    localparam int LEN_W   = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [LEN_W-1:0] MAX_RUN_RESET = 8'd253;

    // one pixel's worth of output words, up to three
    typedef struct packed {
        logic [1:0]       cnt;    // number of words, 1 to 3
        logic             flush;  // last word closes the glyph
        logic [LEN_W-1:0] len0;
        logic [LEN_W-1:0] len1;
        logic [LEN_W-1:0] len2;
    } cmd_t;

endpackage

// ===== rtl/binary_glyph_run_length_encoder.sv =====
// Run-length encoder for one-bit glyph bitmaps. Pixels enter on s_ in raster order
// (s_tlast on the final pixel) and leave as alternating background/foreground run
// lengths on m_, m_tlast marking the final run of a glyph. A pixel is accepted in any
// cycle while the four-entry command queue between the classifier and the output
// sequencer has room, so the block takes one pixel per clock. Each pixel yields zero to
// three output words; the sequencer sends one word per clock unless m_tready is low,
// through a registered output stage; throughput stays at one pixel per cycle while
// results average one word per pixel or less, and bursts (run splits at max_run,
// glyph ends) are absorbed by the queue. A pixel's first word crosses the command
// queue and the registered output stage to reach m_. max_run resets to 253; the user
// must write it via cfg_we / cfg_wdata while idle; the block does not enforce this.
module binary_glyph_run_length_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,     // max_run
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [0] pixel, [7:1] zero
    input  logic       s_tlast,       // last_pixel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] run_length
    output logic       m_tlast        // end_of_glyph
);

    logic                cmd_push;
    logic                cmd_full;
    bgrle_pkg::cmd_t     push_cmd;
    bgrle_pkg::cmd_t     head_cmd;
    logic                pix_accept;
    logic                head_valid;
    logic                head_pop;

    assign s_tready   = !cmd_full;
    assign pix_accept = s_tvalid && s_tready;

    bgrle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .pix_accept (pix_accept),
        .pixel      (s_tdata[0]),
        .last_pixel (s_tlast),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd)
    );

    bgrle_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .wr_cmd   (push_cmd),
        .full     (cmd_full),
        .pop      (head_pop),
        .rd_valid (head_valid),
        .rd_cmd   (head_cmd)
    );

    bgrle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (head_valid),
        .cmd_head  (head_cmd),
        .cmd_pop   (head_pop),
        .out_valid (m_tvalid),
        .out_len   (m_tdata),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

endmodule

// ===== rtl/bgrle_front.sv =====
module bgrle_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [bgrle_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                     pix_accept,
    input  logic                     pixel,
    input  logic                     last_pixel,
    output logic                     cmd_push,
    output bgrle_pkg::cmd_t          cmd
);

    logic                        in_bg_reg, in_bg_next;
    logic [bgrle_pkg::LEN_W-1:0] run_reg, run_next;
    logic [bgrle_pkg::LEN_W-1:0] max_run_reg;

    logic same;
    logic escape;

    always_comb begin
        same       = (pixel != in_bg_reg);
        escape     = same && (run_reg >= max_run_reg);
        in_bg_next = in_bg_reg;
        run_next   = run_reg;
        cmd        = '0;

        if (same) begin
            if (escape) begin
                cmd.len0 = max_run_reg;
                cmd.len1 = '0;
                cmd.cnt  = 2'd2;
                run_next = bgrle_pkg::LEN_W'(1);
            end else begin
                run_next = run_reg + bgrle_pkg::LEN_W'(1);
            end
        end else begin
            cmd.len0   = run_reg;
            cmd.cnt    = 2'd1;
            in_bg_next = !pixel;
            run_next   = bgrle_pkg::LEN_W'(1);
        end

        if (last_pixel) begin
            cmd.flush = 1'b1;
            case (cmd.cnt)
                2'd0:    cmd.len0 = run_next;
                2'd1:    cmd.len1 = run_next;
                default: cmd.len2 = run_next;
            endcase
            cmd.cnt    = cmd.cnt + 2'd1;
            in_bg_next = 1'b1;
            run_next   = '0;
        end

        cmd_push = pix_accept && (cmd.cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_bg_reg   <= 1'b1;
            run_reg     <= '0;
            max_run_reg <= bgrle_pkg::MAX_RUN_RESET;
        end else begin
            if (pix_accept) begin
                in_bg_reg <= in_bg_next;
                run_reg   <= run_next;
            end
            if (cfg_we) begin
                max_run_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/bgrle_cmd_fifo.sv =====
module bgrle_cmd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bgrle_pkg::cmd_t   wr_cmd,
    output logic              full,
    input  logic              pop,
    output logic              rd_valid,
    output bgrle_pkg::cmd_t   rd_cmd
);

    bgrle_pkg::cmd_t mem_reg [bgrle_pkg::FIFO_DEPTH];

    logic [bgrle_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [bgrle_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [bgrle_pkg::FIFO_CW-1:0] count_reg;

    assign full     = (count_reg == bgrle_pkg::FIFO_CW'(bgrle_pkg::FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + bgrle_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + bgrle_pkg::FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + bgrle_pkg::FIFO_CW'(1);
                2'b01:   count_reg <= count_reg - bgrle_pkg::FIFO_CW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> rd_valid)
        else $error("command popped from empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bgrle_pkg::FIFO_CW'(bgrle_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

// ===== rtl/bgrle_back.sv =====
module bgrle_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  bgrle_pkg::cmd_t             cmd_head,
    output logic                        cmd_pop,
    output logic                        out_valid,
    output logic [bgrle_pkg::LEN_W-1:0] out_len,
    output logic                        out_last,
    input  logic                        out_ready
);

    bgrle_pkg::cmd_t cur_reg;
    logic            busy_reg;
    logic [1:0]      idx_reg;
    logic            out_valid_reg;
    logic [bgrle_pkg::LEN_W-1:0] out_len_reg;
    logic            out_last_reg;

    bgrle_pkg::cmd_t src;
    logic [1:0]      idx;
    logic            have;
    logic            load_out;
    logic            final_word;
    logic [bgrle_pkg::LEN_W-1:0] sel_len;

    always_comb begin
        src        = busy_reg ? cur_reg : cmd_head;
        idx        = busy_reg ? idx_reg : 2'd0;
        have       = busy_reg || cmd_valid;
        load_out   = !out_valid_reg || out_ready;
        final_word = (idx == src.cnt - 2'd1);
        case (idx)
            2'd0:    sel_len = src.len0;
            2'd1:    sel_len = src.len1;
            default: sel_len = src.len2;
        endcase
        cmd_pop = load_out && !busy_reg && cmd_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= have;
            if (have) begin
                if (final_word) begin
                    busy_reg <= 1'b0;
                end else begin
                    busy_reg <= 1'b1;
                    idx_reg  <= idx + 2'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (load_out && have) begin
            out_len_reg  <= sel_len;
            out_last_reg <= src.flush && final_word;
        end
        if (cmd_pop) begin
            cur_reg <= cmd_head;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_len   = out_len_reg;
    assign out_last  = out_last_reg;

    a_busy_has_more: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg != 2'd0) && (idx_reg < cur_reg.cnt))
        else $error("sequencer index past end of command");

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> !busy_reg)
        else $error("new command taken while expanding another");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && have && src.flush && final_word) |=> !busy_reg)
        else $error("sequencer still busy after glyph end");

endmodule
